### hdl/sbwc_pkg.sv
// ============================================================================
// sbwc_pkg: shared types and constants for the stream buffer watermark control
// Holds item layouts, state and command codes, reset values and the constant
// reciprocals used to derive the fallback fill levels from the buffer size.
// ============================================================================
`default_nettype none

package sbwc_pkg;

    // ------------------------------------------------------------------
    // Field widths
    // ------------------------------------------------------------------
    localparam int RATE_W     = 10;
    localparam int SIZE_W     = 18;
    localparam int LEVEL_W    = 18;
    localparam int START_W    = 19;
    localparam int DEADLINE_W = 16;
    localparam int RETRY_W    = 4;
    localparam int CFG_DATA_W = 18;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    // ------------------------------------------------------------------
    // Controller parameters
    // ------------------------------------------------------------------
    localparam logic [DEADLINE_W-1:0] TIMEOUT_UNITS = 16'd10;
    localparam logic [RETRY_W-1:0]    RETRIES       = 4'd3;

    // Bitrate substituted for values below the minimum
    localparam logic [RATE_W-1:0] RATE_MIN     = 10'd8;
    localparam logic [RATE_W-1:0] RATE_DEFAULT = 10'd128;

    // ------------------------------------------------------------------
    // Configuration register indexes
    // ------------------------------------------------------------------
    localparam logic CFG_BITRATE = 1'b0;
    localparam logic CFG_BUFFER  = 1'b1;

    // Buffer size after reset and the fill levels derived from it
    localparam logic [SIZE_W-1:0] SIZE_RST       = 18'd65536;
    localparam logic [SIZE_W-1:0] SZ_LOW_RST     = SIZE_W'(65536 / 10);
    localparam logic [SIZE_W-1:0] SZ_RESUME_RST  = SIZE_W'(65536 / 2);
    localparam logic [SIZE_W-1:0] SZ_START_RST   = SIZE_W'((65536 * 4) / 5);

    // Reciprocals: floor(x/10) = (x*DIV10_MUL) >> DIV10_SHIFT for 18-bit x,
    // floor(x/5) = (x*DIV5_MUL) >> DIV5_SHIFT for 20-bit x
    localparam int               DIV10_SHIFT = 22;
    localparam logic [18:0]      DIV10_MUL   = 19'd419431;
    localparam int               DIV5_SHIFT  = 23;
    localparam logic [20:0]      DIV5_MUL    = 21'd1677722;

    // ------------------------------------------------------------------
    // Codes
    // ------------------------------------------------------------------
    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_START   = 2'd1,
        REQ_OUTCOME = 2'd2,
        REQ_STOP    = 2'd3
    } t_req;

    localparam logic [1:0] OUT_OPENED = 2'd0;
    localparam logic [1:0] OUT_MOVED  = 2'd1;

    typedef enum logic [3:0] {
        M_CLOSED     = 4'b0001,
        M_CONNECTING = 4'b0010,
        M_PLAYING    = 4'b0100,
        M_BUFFERING  = 4'b1000
    } t_mode;

    localparam logic [1:0] PS_CLOSED     = 2'd0;
    localparam logic [1:0] PS_CONNECTING = 2'd1;
    localparam logic [1:0] PS_PLAYING    = 2'd2;
    localparam logic [1:0] PS_BUFFERING  = 2'd3;

    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_START   = 3'd1,
        CMD_PLAY    = 3'd2,
        CMD_PAUSE   = 3'd3,
        CMD_STOP    = 3'd4,
        CMD_RESTART = 3'd5
    } t_cmd;

    // ------------------------------------------------------------------
    // Structures
    // ------------------------------------------------------------------
    typedef struct packed {
        t_req               req_type;
        logic [LEVEL_W-1:0] buffer_level;
        logic               time_tick;
        logic [1:0]         open_outcome;
    } t_item;

    typedef struct packed {
        logic [1:0]         play_state;
        t_cmd               decoder_cmd;
        logic               reopen_request;
        logic [RETRY_W-1:0] retries_left;
    } t_result;

    typedef struct packed {
        logic [LEVEL_W-1:0] low;
        logic [LEVEL_W-1:0] resume;
        logic [START_W-1:0] start;
    } t_levels;

    // Map the internal one-hot mode to the reported play state
    function automatic logic [1:0] mode_code(input t_mode m);
        logic [1:0] code;
        case (m)
            M_CONNECTING: code = PS_CONNECTING;
            M_PLAYING:    code = PS_PLAYING;
            M_BUFFERING:  code = PS_BUFFERING;
            default:      code = PS_CLOSED;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### hdl/sbwc_levels.sv
// ============================================================================
// sbwc_levels: configuration registers and fill level derivation
// Holds bitrate and buffer size, precomputes the size-based levels on each
// size write, and selects bitrate- or size-based low/resume/start levels.
// ============================================================================
`default_nettype none

module sbwc_levels (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [sbwc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                             i_rate_clr,
    output sbwc_pkg::t_levels                     o_levels
);

    logic [sbwc_pkg::RATE_W-1:0]  r_bitrate;
    logic [sbwc_pkg::SIZE_W-1:0]  r_size;
    logic [sbwc_pkg::SIZE_W-1:0]  r_sz_low;
    logic [sbwc_pkg::SIZE_W-1:0]  r_sz_resume;
    logic [sbwc_pkg::SIZE_W-1:0]  r_sz_start;

    logic [36:0]                  w_prod10;
    logic [19:0]                  w_size_x4;
    logic [40:0]                  w_prod5;
    logic [sbwc_pkg::SIZE_W-1:0]  n_sz_low;
    logic [sbwc_pkg::SIZE_W-1:0]  n_sz_resume;
    logic [sbwc_pkg::SIZE_W-1:0]  n_sz_start;

    logic [sbwc_pkg::RATE_W-1:0]  w_rate;
    logic [15:0]                  w_low_b;
    logic [sbwc_pkg::START_W-1:0] w_start_b;
    logic                         w_use_size;

    // Size-based levels from the write data: 10%, 50% and 80%
    assign w_prod10    = 37'(i_cfg_wdata) * 37'(sbwc_pkg::DIV10_MUL);
    assign w_size_x4   = {i_cfg_wdata, 2'b00};
    assign w_prod5     = 41'(w_size_x4) * 41'(sbwc_pkg::DIV5_MUL);
    assign n_sz_low    = {3'b000, w_prod10[36:sbwc_pkg::DIV10_SHIFT]};
    assign n_sz_resume = {1'b0, i_cfg_wdata[sbwc_pkg::SIZE_W-1:1]};
    assign n_sz_start  = w_prod5[40:sbwc_pkg::DIV5_SHIFT];

    // Hold configuration; an open attempt clears the bitrate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bitrate   <= '0;
            r_size      <= sbwc_pkg::SIZE_RST;
            r_sz_low    <= sbwc_pkg::SZ_LOW_RST;
            r_sz_resume <= sbwc_pkg::SZ_RESUME_RST;
            r_sz_start  <= sbwc_pkg::SZ_START_RST;
        end else begin
            if (i_rate_clr) begin
                r_bitrate <= '0;
            end
            if (i_cfg_we && i_cfg_idx == sbwc_pkg::CFG_BITRATE) begin
                r_bitrate <= i_cfg_wdata[sbwc_pkg::RATE_W-1:0];
            end
            if (i_cfg_we && i_cfg_idx == sbwc_pkg::CFG_BUFFER) begin
                r_size      <= i_cfg_wdata;
                r_sz_low    <= n_sz_low;
                r_sz_resume <= n_sz_resume;
                r_sz_start  <= n_sz_start;
            end
        end
    end

    // Bitrate-based levels: low = (rate/8)*512, resume = 4*low, start = 8*low
    assign w_rate     = (r_bitrate < sbwc_pkg::RATE_MIN) ? sbwc_pkg::RATE_DEFAULT : r_bitrate;
    assign w_low_b    = {w_rate[sbwc_pkg::RATE_W-1:3], 9'd0};
    assign w_start_b  = {w_low_b, 3'b000};
    assign w_use_size = (w_start_b >= {1'b0, r_size});

    // Fall back to size-based levels once start reaches the buffer size
    always_comb begin
        if (w_use_size) begin
            o_levels.low    = r_sz_low;
            o_levels.resume = r_sz_resume;
            o_levels.start  = {1'b0, r_sz_start};
        end else begin
            o_levels.low    = {2'b00, w_low_b};
            o_levels.resume = {w_low_b, 2'b00};
            o_levels.start  = w_start_b;
        end
    end

endmodule

`default_nettype wire

### hdl/sbwc_ctrl.sv
// ============================================================================
// sbwc_ctrl: playout controller step
// Input register, mode/deadline/retry state and the result register; one
// item advances from input to result register per cycle unless the result side stalls.
// ============================================================================
`default_nettype none

module sbwc_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire sbwc_pkg::t_item    i_item,
    input  wire sbwc_pkg::t_levels  i_levels,
    output logic                    o_rate_clr,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output sbwc_pkg::t_result       o_result
);

    logic                                r_in_valid;
    sbwc_pkg::t_item                     r_in;
    logic                                r_out_valid;
    sbwc_pkg::t_result                   r_out;

    sbwc_pkg::t_mode                     r_mode;
    logic [sbwc_pkg::DEADLINE_W-1:0]     r_deadline;
    logic [sbwc_pkg::RETRY_W-1:0]        r_retry;

    sbwc_pkg::t_mode                     n_mode;
    logic [sbwc_pkg::DEADLINE_W-1:0]     n_deadline;
    logic [sbwc_pkg::RETRY_W-1:0]        n_retry;
    sbwc_pkg::t_cmd                      w_cmd;
    logic                                w_reopen;
    logic                                w_clr;
    logic                                w_adv;
    logic                                w_expired;
    logic                                w_count;

    // Advance when the result register is free or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_rate_clr  = w_adv && w_clr;

    // Deadline handling on a timeout unit
    assign w_expired = r_in.time_tick && (r_deadline == '0);
    assign w_count   = r_in.time_tick && (r_deadline != '0);

    // Step the controller for the held item
    always_comb begin
        n_mode     = r_mode;
        n_deadline = r_deadline;
        n_retry    = r_retry;
        w_cmd      = sbwc_pkg::CMD_NONE;
        w_reopen   = 1'b0;
        w_clr      = 1'b0;
        case (r_in.req_type)
            sbwc_pkg::REQ_START: begin
                n_retry    = sbwc_pkg::RETRIES;
                n_mode     = sbwc_pkg::M_CONNECTING;
                n_deadline = sbwc_pkg::TIMEOUT_UNITS;
                w_cmd      = sbwc_pkg::CMD_START;
                w_reopen   = 1'b1;
                w_clr      = 1'b1;
            end
            sbwc_pkg::REQ_OUTCOME: begin
                if (r_mode == sbwc_pkg::M_CONNECTING) begin
                    if (r_in.open_outcome == sbwc_pkg::OUT_OPENED) begin
                        n_deadline = sbwc_pkg::TIMEOUT_UNITS;
                    end else if (r_in.open_outcome == sbwc_pkg::OUT_MOVED) begin
                        n_deadline = '0;
                    end else begin
                        w_cmd   = sbwc_pkg::CMD_STOP;
                        n_mode  = sbwc_pkg::M_CLOSED;
                        n_retry = sbwc_pkg::RETRIES;
                    end
                end
            end
            sbwc_pkg::REQ_STOP: begin
                if (r_mode != sbwc_pkg::M_CLOSED) begin
                    w_cmd = sbwc_pkg::CMD_STOP;
                end
                n_mode  = sbwc_pkg::M_CLOSED;
                n_retry = sbwc_pkg::RETRIES;
            end
            default: begin
                case (r_mode)
                    sbwc_pkg::M_PLAYING: begin
                        n_deadline = sbwc_pkg::TIMEOUT_UNITS;
                        if (r_in.buffer_level < i_levels.low) begin
                            n_mode = sbwc_pkg::M_BUFFERING;
                            w_cmd  = sbwc_pkg::CMD_PAUSE;
                        end else begin
                            w_cmd  = sbwc_pkg::CMD_PLAY;
                        end
                    end
                    sbwc_pkg::M_BUFFERING: begin
                        if (r_in.buffer_level > i_levels.resume) begin
                            n_mode = sbwc_pkg::M_PLAYING;
                            w_cmd  = sbwc_pkg::CMD_PLAY;
                        end
                        if (w_count) begin
                            n_deadline = r_deadline - 1'b1;
                        end
                        // Buffering timeout overrides a resume
                        if (w_expired) begin
                            w_cmd      = sbwc_pkg::CMD_STOP;
                            n_mode     = sbwc_pkg::M_CONNECTING;
                            n_deadline = sbwc_pkg::DEADLINE_W'(1);
                        end
                    end
                    sbwc_pkg::M_CONNECTING: begin
                        if ({1'b0, r_in.buffer_level} > i_levels.start) begin
                            n_mode = sbwc_pkg::M_PLAYING;
                            w_cmd  = sbwc_pkg::CMD_PLAY;
                        end
                        if (w_count) begin
                            n_deadline = r_deadline - 1'b1;
                        end
                        // Connect timeout: retry while budget remains
                        if (w_expired) begin
                            w_cmd  = sbwc_pkg::CMD_STOP;
                            n_mode = sbwc_pkg::M_CLOSED;
                            if (r_retry != '0) begin
                                n_retry    = r_retry - 1'b1;
                                n_mode     = sbwc_pkg::M_CONNECTING;
                                n_deadline = sbwc_pkg::TIMEOUT_UNITS;
                                w_cmd      = sbwc_pkg::CMD_RESTART;
                                w_reopen   = 1'b1;
                                w_clr      = 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        endcase
    end

    // Hold valid flags and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= sbwc_pkg::M_CLOSED;
            r_deadline  <= '0;
            r_retry     <= sbwc_pkg::RETRIES;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_deadline  <= n_deadline;
                r_retry     <= n_retry;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture payloads
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_item;
        end
        if (w_adv) begin
            r_out.play_state     <= sbwc_pkg::mode_code(n_mode);
            r_out.decoder_cmd    <= w_cmd;
            r_out.reopen_request <= w_reopen;
            r_out.retries_left   <= n_retry;
        end
    end

endmodule

`default_nettype wire

### hdl/stream_buffer_watermark_control_core.sv
// ============================================================================
// stream_buffer_watermark_control_core: playout buffer watermark controller
// Streams service items in and one decoder command result per item out.
// ============================================================================
// Takes one item per clock, unless the result side stalls, and returns
// exactly one result per item, in order. An accepted item lands in an input
// register and moves to the result register at the next edge at which the
// result register is free or being emptied, and is offered there until
// taken; with the output side ready the sustained rate is one item
// per cycle, set by the single registered controller step. Fill levels
// follow the bitrate register (low = rate/8*512, resume = 4*low, start =
// 8*low, 128 kb/s below 8) or, when start reaches the buffer size, 10%, 50%
// and 80% of the size; the size-based levels are computed when the size is
// written. Write configuration only while no item is in flight; a start
// request or a reconnect attempt clears the bitrate register.
`default_nettype none

module stream_buffer_watermark_control_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration write port
    input  wire logic                             i_cfg_we,
    input  wire logic                             i_cfg_idx,
    input  wire logic [sbwc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Service items in
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // buffer_level[17:0], time_tick[18], open_outcome[20:19], zero[23:21]
    input  wire logic [sbwc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // req_type[1:0]
    input  wire logic [1:0]                       s_axis_tuser,
    // Results out
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // play_state[1:0], decoder_cmd[4:2], reopen_request[5],
    // retries_left[9:6], zero[15:10]
    output logic [sbwc_pkg::M_TDATA_W-1:0]        m_axis_tdata
);

    sbwc_pkg::t_item   w_item;
    sbwc_pkg::t_levels w_levels;
    sbwc_pkg::t_result w_result;
    logic              w_rate_clr;

    // Unpack the incoming item
    assign w_item.req_type     = sbwc_pkg::t_req'(s_axis_tuser);
    assign w_item.buffer_level = s_axis_tdata[17:0];
    assign w_item.time_tick    = s_axis_tdata[18];
    assign w_item.open_outcome = s_axis_tdata[20:19];

    sbwc_levels u_levels (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rate_clr  (w_rate_clr),
        .o_levels    (w_levels)
    );

    sbwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_item      (w_item),
        .i_levels    (w_levels),
        .o_rate_clr  (w_rate_clr),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (w_result)
    );

    // Pack the result item
    assign m_axis_tdata = {6'd0, w_result.retries_left, w_result.reopen_request,
                           w_result.decoder_cmd, w_result.play_state};

endmodule

`default_nettype wire

### hdl/sbwc_checker.sv
// ============================================================================
// sbwc_checker: port-level checks for the watermark controller
// Watches the result stream for consistent command, state and reopen fields.
// ============================================================================
`default_nettype none

module sbwc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [sbwc_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // A reopen comes only with a start or a restart command
    a_reopen_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |->
        (m_axis_tdata[4:2] == sbwc_pkg::CMD_START ||
         m_axis_tdata[4:2] == sbwc_pkg::CMD_RESTART))
        else $error("reopen without start command");

    // A reopen always leaves the controller connecting
    a_reopen_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[5]) |->
        (m_axis_tdata[1:0] == sbwc_pkg::PS_CONNECTING))
        else $error("reopen outside connecting");

    // A pause always leaves the controller buffering
    a_pause_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4:2] == sbwc_pkg::CMD_PAUSE) |->
        (m_axis_tdata[1:0] == sbwc_pkg::PS_BUFFERING))
        else $error("pause outside buffering");

endmodule

bind stream_buffer_watermark_control_core sbwc_checker u_sbwc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/stream_buffer_watermark_control_core_tb.sv
// ============================================================================
// stream_buffer_watermark_control_core_tb: self-checking playout controller test
// Drives service, start, outcome and stop items into the controller under
// changing bitrate and buffer size settings. A scoreboard tracks mode,
// deadline and retry budget and checks every decoder command result.
// ============================================================================
`default_nettype none

module stream_buffer_watermark_control_core_tb;
    import sbwc_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int LEVEL_MAX      = 131072;
    localparam int PRESSURE_PHASE = 8;

    localparam logic [1:0] OUT_ERROR = 2'd2;
    localparam logic [1:0] OUT_ODD   = 2'd3;

    // ------------------------------------------------------------------
    // Scoreboard: watermark and reconnect tracking, expected commands
    // ------------------------------------------------------------------
    class watermark_scoreboard;
        logic [RATE_W-1:0]     rate_reg;
        logic [SIZE_W-1:0]     size_reg;
        logic [1:0]            mode;
        logic [DEADLINE_W-1:0] deadline;
        logic [RETRY_W-1:0]    retries;
        t_result               pending_cmds[$];
        int                    errors;
        int                    checked;
        int                    req_seen[4];
        int                    cmd_seen[8];

        function new();
            rate_reg = '0;
            size_reg = SIZE_RST;
            mode     = PS_CLOSED;
            deadline = '0;
            retries  = RETRIES;
            errors   = 0;
            checked  = 0;
        endfunction

        function void note_config(input logic idx, input logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_BITRATE) begin
                rate_reg = value[RATE_W-1:0];
            end else begin
                size_reg = value[SIZE_W-1:0];
            end
        endfunction

        // Bitrate watermarks, or fixed shares of the size when start won't fit
        function void levels(output int unsigned lo, output int unsigned re,
                             output int unsigned st);
            int unsigned rate;
            int unsigned sz;
            rate = rate_reg;
            sz   = size_reg;
            if (rate < RATE_MIN) begin
                rate = RATE_DEFAULT;
            end
            lo = (rate / 8) * 512;
            re = lo * 4;
            st = lo * 8;
            if (st >= sz) begin
                lo = sz * 10 / 100;
                re = sz * 50 / 100;
                st = sz * 80 / 100;
            end
        endfunction

        // Consume one timeout unit; report expiry once the deadline is spent
        function bit deadline_hit(input bit tick);
            if (!tick) begin
                return 1'b0;
            end
            if (deadline == '0) begin
                return 1'b1;
            end
            deadline = deadline - 1'b1;
            return 1'b0;
        endfunction

        function void reopen_stream();
            rate_reg = '0;
            mode     = PS_CONNECTING;
            deadline = TIMEOUT_UNITS;
        endfunction

        function void note_request(input t_item it);
            int unsigned lo, re, st;
            t_cmd        cmd;
            logic        reopen;
            t_result     r;
            levels(lo, re, st);
            cmd    = CMD_NONE;
            reopen = 1'b0;
            req_seen[it.req_type]++;
            case (it.req_type)
                REQ_START: begin
                    retries = RETRIES;
                    reopen_stream();
                    cmd    = CMD_START;
                    reopen = 1'b1;
                end
                REQ_OUTCOME: begin
                    // outcomes only matter while a connection is pending
                    if (mode == PS_CONNECTING) begin
                        if (it.open_outcome == OUT_OPENED) begin
                            deadline = TIMEOUT_UNITS;
                        end else if (it.open_outcome == OUT_MOVED) begin
                            deadline = '0;
                        end else begin
                            cmd     = CMD_STOP;
                            mode    = PS_CLOSED;
                            retries = RETRIES;
                        end
                    end
                end
                REQ_STOP: begin
                    if (mode != PS_CLOSED) begin
                        cmd = CMD_STOP;
                    end
                    mode    = PS_CLOSED;
                    retries = RETRIES;
                end
                default: begin
                    case (mode)
                        PS_PLAYING: begin
                            deadline = TIMEOUT_UNITS;
                            if (it.buffer_level < lo) begin
                                mode = PS_BUFFERING;
                                cmd  = CMD_PAUSE;
                            end else begin
                                cmd = CMD_PLAY;
                            end
                        end
                        PS_BUFFERING: begin
                            if (it.buffer_level > re) begin
                                mode = PS_PLAYING;
                                cmd  = CMD_PLAY;
                            end
                            // a timeout wins over a resume in the same step
                            if (deadline_hit(it.time_tick)) begin
                                cmd      = CMD_STOP;
                                mode     = PS_CONNECTING;
                                deadline = DEADLINE_W'(1);
                            end
                        end
                        PS_CONNECTING: begin
                            if (it.buffer_level > st) begin
                                mode = PS_PLAYING;
                                cmd  = CMD_PLAY;
                            end
                            if (deadline_hit(it.time_tick)) begin
                                cmd  = CMD_STOP;
                                mode = PS_CLOSED;
                                if (retries != '0) begin
                                    retries = retries - 1'b1;
                                    reopen_stream();
                                    cmd    = CMD_RESTART;
                                    reopen = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            endcase
            cmd_seen[cmd]++;
            r.play_state     = mode;
            r.decoder_cmd    = cmd;
            r.reopen_request = reopen;
            r.retries_left   = retries;
            pending_cmds.push_back(r);
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] d);
            t_result e;
            checked++;
            if (pending_cmds.size() == 0) begin
                $error("result 0x%0h arrived with no request outstanding", d);
                errors++;
                return;
            end
            e = pending_cmds.pop_front();
            if (d[1:0] !== e.play_state) begin
                $error("play_state: expected %0d, got %0d", e.play_state, d[1:0]);
                errors++;
            end
            if (d[4:2] !== e.decoder_cmd) begin
                $error("decoder_cmd: expected %0d, got %0d", e.decoder_cmd, d[4:2]);
                errors++;
            end
            if (d[5] !== e.reopen_request) begin
                $error("reopen_request: expected %0d, got %0d", e.reopen_request, d[5]);
                errors++;
            end
            if (d[9:6] !== e.retries_left) begin
                $error("retries_left: expected %0d, got %0d", e.retries_left, d[9:6]);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    watermark_scoreboard sb;
    bit   idle_on = 1'b1;
    bit   hold_go = 1'b0;
    logic rx_hold;
    int   n_in = 0;
    int   n_out = 0;
    int   n_settings = 0;

    stream_buffer_watermark_control_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Item construction
    // ------------------------------------------------------------------
    function automatic t_item request_item(input t_req r, input int unsigned lvl,
                                           input bit tk, input logic [1:0] oc);
        t_item it;
        it.req_type     = r;
        it.buffer_level = lvl[LEVEL_W-1:0];
        it.time_tick    = tk;
        it.open_outcome = oc;
        return it;
    endfunction

    // Pick a request that fits the current mode, with levels near the marks
    function automatic t_item make_item(input bit dry);
        t_item       it;
        int unsigned lo, re, st, pick;
        int          lvl;
        sb.levels(lo, re, st);
        it.req_type     = REQ_TICK;
        it.buffer_level = LEVEL_W'($urandom_range(0, LEVEL_MAX));
        it.time_tick    = ($urandom_range(0, 99) < (dry ? 80 : 35));
        it.open_outcome = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        case (sb.mode)
            PS_CLOSED: begin
                if (pick < 60) begin
                    it.req_type = REQ_START;
                end else if (pick < 70) begin
                    it.req_type = REQ_STOP;
                end else if (pick < 80) begin
                    it.req_type = REQ_OUTCOME;
                end
            end
            PS_CONNECTING: begin
                if (pick < 20) begin
                    it.req_type = REQ_OUTCOME;
                    pick = $urandom_range(0, 9);
                    it.open_outcome = (pick < 5) ? OUT_OPENED :
                                      (pick < 8) ? OUT_MOVED  :
                                      (pick < 9) ? OUT_ERROR  : OUT_ODD;
                end else if (pick < 23) begin
                    it.req_type = REQ_STOP;
                end else if (pick < 25) begin
                    it.req_type = REQ_START;
                end
            end
            default: begin
                if (pick < 3) begin
                    it.req_type = REQ_STOP;
                end else if (pick < 5) begin
                    it.req_type = REQ_START;
                end else if (pick < 10) begin
                    it.req_type = REQ_OUTCOME;
                end
            end
        endcase
        if (it.req_type == REQ_TICK) begin
            pick = $urandom_range(0, 9);
            if (dry) begin
                lvl = int'($urandom_range(0, lo));
            end else begin
                case (pick)
                    0, 1:    lvl = int'(lo) + int'($urandom_range(0, 2)) - 1;
                    2, 3:    lvl = int'(re) + int'($urandom_range(0, 2)) - 1;
                    4, 5:    lvl = int'(st) + int'($urandom_range(0, 2)) - 1;
                    6:       lvl = 0;
                    7:       lvl = LEVEL_MAX;
                    default: lvl = int'($urandom_range(0, LEVEL_MAX));
                endcase
            end
            if (lvl < 0) begin
                lvl = 0;
            end
            if (lvl > LEVEL_MAX) begin
                lvl = LEVEL_MAX;
            end
            it.buffer_level = LEVEL_W'(lvl);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one item after a random gap; return at the accepting edge
    task automatic send_item(input t_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it.open_outcome, it.time_tick, it.buffer_level};
        s_axis_tuser  <= it.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(it);
        n_in++;
    endtask

    // Drop valid and wait for every outstanding result, then let the core go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [RATE_W-1:0] rate,
                                 input logic [SIZE_W-1:0] size);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_BUFFER;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_BITRATE;
        i_cfg_wdata <= CFG_DATA_W'(rate);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.note_config(CFG_BUFFER, size);
        sb.note_config(CFG_BITRATE, CFG_DATA_W'(rate));
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random per-item stalls plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int rx_gap;
        rx_gap = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
                n_out++;
                rx_gap = idle_on ? $urandom_range(0, 7) : 0;
            end else if (rx_gap != 0) begin
                rx_gap--;
            end
            m_axis_tready <= !rx_hold && (rx_gap == 0) && i_rst_n;
        end
    end

    initial begin
        rx_hold <= 1'b0;
        wait (hold_go);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // Abort when neither side moves an item for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                phase;
        int                n_rand;
        int                n_items;
        int unsigned       pick;
        bit                dry;
        logic [RATE_W-1:0] rate;
        logic [SIZE_W-1:0] size;

        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_BITRATE;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= REQ_TICK;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Directed walk with the reset levels (size based: 10/50/80 percent)
        send_item(request_item(REQ_TICK, 0, 1'b1, OUT_OPENED));
        send_item(request_item(REQ_OUTCOME, 0, 1'b0, OUT_OPENED));
        send_item(request_item(REQ_STOP, LEVEL_MAX, 1'b1, OUT_ODD));
        send_item(request_item(REQ_START, 0, 1'b0, OUT_OPENED));
        // outcome code 3 counts as an open error
        send_item(request_item(REQ_OUTCOME, 0, 1'b0, OUT_ODD));
        send_item(request_item(REQ_START, 0, 1'b0, OUT_OPENED));
        // moved address zeroes the deadline, next tick reconnects
        send_item(request_item(REQ_OUTCOME, 0, 1'b0, OUT_MOVED));
        send_item(request_item(REQ_TICK, 0, 1'b1, OUT_OPENED));
        send_item(request_item(REQ_OUTCOME, 0, 1'b0, OUT_OPENED));
        send_item(request_item(REQ_TICK, SZ_START_RST, 1'b0, OUT_OPENED));
        send_item(request_item(REQ_TICK, SZ_START_RST + 1, 1'b1, OUT_OPENED));
        send_item(request_item(REQ_TICK, SZ_LOW_RST, 1'b0, OUT_OPENED));
        send_item(request_item(REQ_TICK, SZ_LOW_RST - 1, 1'b0, OUT_OPENED));
        // run the buffering deadline down while sitting on the resume mark
        repeat (TIMEOUT_UNITS) begin
            send_item(request_item(REQ_TICK, SZ_RESUME_RST, 1'b1, OUT_OPENED));
        end
        // resume and expiry together: the timeout wins
        send_item(request_item(REQ_TICK, LEVEL_MAX, 1'b1, OUT_OPENED));
        send_item(request_item(REQ_OUTCOME, LEVEL_MAX, 1'b1, OUT_ERROR));
        send_item(request_item(REQ_TICK, LEVEL_MAX, 1'b1, OUT_ERROR));

        // Random phases, each under its own register setting
        phase  = 0;
        n_rand = 0;
        while (n_rand < RANDOM_ITEMS) begin
            case (phase)
                0: begin rate = 10'd0;    size = 18'd0;      end
                1: begin rate = 10'd7;    size = 18'd1;      end
                2: begin rate = 10'd8;    size = 18'd131072; end
                3: begin rate = 10'd1023; size = 18'd131072; end
                4: begin rate = 10'd1023; size = 18'd1;      end
                5: begin rate = 10'd255;  size = 18'd131072; end
                default: begin
                    pick = $urandom_range(0, 9);
                    if (pick < 2) begin
                        size = 18'd131072;
                    end else if (pick < 3) begin
                        size = SIZE_W'($urandom_range(1, 64));
                    end else begin
                        size = SIZE_W'($urandom_range(1, LEVEL_MAX));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        rate = RATE_W'($urandom_range(8, 260));
                    end else begin
                        rate = RATE_W'($urandom_range(0, 1023));
                    end
                end
            endcase
            idle_on = (phase % 4) != 3;
            dry     = (phase % 5) == 4;
            settle();
            // open first so the bitrate written next is not wiped by the start
            if ($urandom_range(0, 4) != 0) begin
                send_item(request_item(REQ_START, $urandom_range(0, LEVEL_MAX), 1'b0,
                                       OUT_OPENED));
                send_item(request_item(REQ_OUTCOME, $urandom_range(0, LEVEL_MAX), 1'b1,
                                       OUT_OPENED));
                settle();
            end
            load_settings(rate, size);
            n_items = $urandom_range(15, 40);
            if (phase == PRESSURE_PHASE) begin
                idle_on = 1'b0;
                n_items = 60;
                hold_go = 1'b1;
            end
            repeat (n_items) begin
                send_item(make_item(dry));
                n_rand++;
            end
            phase++;
        end
        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d items (%0d ticks, %0d starts, %0d outcomes, %0d stops)",
                 n_in, sb.req_seen[REQ_TICK], sb.req_seen[REQ_START],
                 sb.req_seen[REQ_OUTCOME], sb.req_seen[REQ_STOP]);
        $display("under %0d settings; checked %0d results: %0d plays, %0d pauses,",
                 n_settings, sb.checked, sb.cmd_seen[CMD_PLAY], sb.cmd_seen[CMD_PAUSE]);
        $display("%0d stops, %0d reconnects.",
                 sb.cmd_seen[CMD_STOP], sb.cmd_seen[CMD_RESTART]);
        if (sb.errors == 0 && sb.pending_cmds.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
